FILE: rtl/varint_7z_number_codec_macros.svh
// Assertion helpers used by the checker file.
`ifndef VARINT_7Z_NUMBER_CODEC_MACROS_SVH
`define VARINT_7Z_NUMBER_CODEC_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define V7Z_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

// Next-cycle implication, disabled while reset is held.
`define V7Z_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

FILE: rtl/v7z_pkg.sv
package v7z_pkg;

  localparam int ValueW   = 64;
  localparam int ByteW    = 8;
  localparam int LenW     = 4;
  localparam int MaxLen   = 9;
  localparam int LaneCnt  = ValueW / ByteW;
  localparam logic [ByteW-1:0] HeadTop = 8'h80;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } v7z_mode_t;

  // What one decode byte produces, handed from the decoder to the top level.
  typedef struct packed {
    logic              has_result;
    logic [ValueW-1:0] value;
    logic              value_valid;
    logic [LenW-1:0]   length;
    logic              status;
  } v7z_dec_res_t;

  // Count of leading one bits of a head byte, 0 to 8.
  function automatic logic [LenW-1:0] lead_ones(input logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    logic            run;
    n   = '0;
    run = 1'b1;
    for (int k = ByteW - 1; k >= 0; k--) begin
      run = run & b[k];
      if (run) n = n + 4'd1;
    end
    return n;
  endfunction

  // Number of bytes that follow the head byte when a value is encoded.
  function automatic logic [LenW-1:0] enc_extra(input logic [ValueW-1:0] v);
    logic [LenW-1:0] n;
    n = 4'd8;
    for (int k = 7; k >= 0; k--) begin
      if ((v >> (7 * (k + 1))) == '0) n = LenW'(k);
    end
    return n;
  endfunction

  // Byte lane idx of a 64-bit word.
  function automatic logic [ByteW-1:0] byte_of(input logic [ValueW-1:0] v,
                                                input logic [2:0] idx);
    return v[ByteW*idx +: ByteW];
  endfunction

endpackage

FILE: rtl/v7z_decoder.sv
module v7z_decoder
  import v7z_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ByteW-1:0]  dec_byte,
  input  logic              dec_eod,
  input  logic              dec_step,
  output v7z_dec_res_t      dec_res
);

  logic [LenW-1:0]   bytes_seen_r, bytes_seen_nxt;
  logic [LenW-1:0]   expected_length_r, expected_length_nxt;
  logic [ByteW-1:0]  head_byte_r, head_byte_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;

  logic              first;
  logic [LenW-1:0]   seen_m1;
  logic [LenW-1:0]   n_final;
  logic [ByteW-1:0]  top_mask;
  logic [ByteW-1:0]  top_bits;
  logic [ValueW-1:0] value;
  logic              complete;

  always_comb begin
    first               = (bytes_seen_r == '0);
    seen_m1             = bytes_seen_r - 4'd1;
    bytes_seen_nxt      = first ? 4'd1 : bytes_seen_r + 4'd1;
    expected_length_nxt = first ? lead_ones(dec_byte) + 4'd1 : expected_length_r;
    head_byte_nxt       = first ? dec_byte : head_byte_r;
    for (int j = 0; j < LaneCnt; j++) begin
      if (first) begin
        acc_nxt[ByteW*j +: ByteW] = '0;
      end else if (seen_m1[2:0] == 3'(j)) begin
        acc_nxt[ByteW*j +: ByteW] = acc_r[ByteW*j +: ByteW] | dec_byte;
      end else begin
        acc_nxt[ByteW*j +: ByteW] = acc_r[ByteW*j +: ByteW];
      end
    end

    complete = (bytes_seen_nxt >= expected_length_nxt);

    // The head byte's bits below its terminating zero form the top byte.
    // A nine-byte number has no such bits, so no lane matches then.
    n_final  = expected_length_nxt - 4'd1;
    top_mask = (HeadTop >> n_final) - 8'd1;
    top_bits = head_byte_nxt & top_mask;
    value    = acc_nxt;
    for (int j = 0; j < LaneCnt; j++) begin
      if (n_final == LenW'(j)) begin
        value[ByteW*j +: ByteW] = acc_nxt[ByteW*j +: ByteW] | top_bits;
      end
    end

    dec_res.has_result  = complete | dec_eod;
    dec_res.value       = complete ? value : '0;
    dec_res.value_valid = complete;
    dec_res.length      = complete ? expected_length_nxt : '0;
    dec_res.status      = ~complete;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r      <= '0;
      expected_length_r <= '0;
      head_byte_r       <= '0;
      acc_r             <= '0;
    end else if (dec_step) begin
      if (dec_res.has_result) begin
        bytes_seen_r      <= '0;
        expected_length_r <= '0;
        head_byte_r       <= '0;
        acc_r             <= '0;
      end else begin
        bytes_seen_r      <= bytes_seen_nxt;
        expected_length_r <= expected_length_nxt;
        head_byte_r       <= head_byte_nxt;
        acc_r             <= acc_nxt;
      end
    end
  end

endmodule

FILE: rtl/varint_7z_number_codec.sv
// Codec for the 7z variable-length 64-bit number format.
// The input channel (in_valid/in_ready) carries one transaction per item: in encode
// mode a 64-bit value, in decode mode one coded byte with an end-of-data mark.
// The result channel (out_valid/out_ready) carries one transaction per coded byte
// when encoding (one to nine, the last one flagged by out_byte_last) and at most
// one transaction per decode byte: the finished number, or a truncation report.
// A decode byte that neither completes a number nor ends the data gives nothing.
// Each transaction is held in the input register and its result in the output register.
// Throughput: a decode byte every cycle unless a result waits on a stalled receiver;
// an encoded value holds the input register for its n+1 coded bytes, n being the
// number of bytes after the head byte, moved one per cycle while out_ready allows.
// An input register in front of the core takes the next transaction while a result
// is still waiting in the output register, so a stalled receiver costs one slot of
// buffering before in_ready drops. While out_ready is low the result is held.
// An encode transaction leaves a partially decoded number untouched.
// Reset (rst_n low at a clock edge) empties both registers and returns the decoder
// to the start of a number.
module varint_7z_number_codec
  import v7z_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [ValueW-1:0] in_plain_value,
  input  logic [ByteW-1:0]  in_byte,
  input  logic              in_end_of_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ByteW-1:0]  out_byte,
  output logic              out_byte_last,
  output logic [ValueW-1:0] out_decoded_value,
  output logic              out_value_valid,
  output logic [LenW-1:0]   out_coded_length,
  output logic              out_status
);

  // Input register.
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_mode_r;
  logic [ValueW-1:0] s1_value_r;
  logic [ByteW-1:0]  s1_byte_r;
  logic              s1_eod_r;

  // Index of the next coded byte of the value being encoded (0 is the head).
  logic [LenW-1:0]   enc_idx_r, enc_idx_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [ByteW-1:0]  out_byte_r;
  logic              out_last_r;
  logic [ValueW-1:0] out_value_r;
  logic              out_vvalid_r;
  logic [LenW-1:0]   out_len_r;
  logic              out_status_r;

  logic              in_fire;
  logic              out_load;
  logic              is_decode;
  logic              s1_step;
  logic              s1_retire;
  logic              out_push;
  logic              dec_step;
  v7z_dec_res_t      dec_res;

  logic [LenW-1:0]   enc_n;
  logic [LenW-1:0]   enc_pos;
  logic [ByteW-1:0]  enc_head;
  logic [ByteW-1:0]  enc_byte;
  logic              enc_last;

  v7z_decoder u_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .dec_byte (s1_byte_r),
    .dec_eod  (s1_eod_r),
    .dec_step (dec_step),
    .dec_res  (dec_res)
  );

  // Encoder: the head byte holds n leading ones and the value's top bits,
  // then the low bytes follow, least significant first.
  always_comb begin
    enc_n    = enc_extra(s1_value_r);
    enc_pos  = enc_idx_r - 4'd1;
    enc_head = ~(8'hFF >> enc_n);
    if (enc_n != 4'd8) begin
      enc_head = enc_head | byte_of(s1_value_r, enc_n[2:0]);
    end
    enc_byte = (enc_idx_r == '0) ? enc_head : byte_of(s1_value_r, enc_pos[2:0]);
    enc_last = (enc_idx_r == enc_n);
  end

  // Flow control. A decode byte that gives no result never waits on the output.
  always_comb begin
    is_decode = (s1_mode_r == MODE_DECODE);
    out_load  = ~out_valid_r | out_ready;
    s1_step   = s1_valid_r & (is_decode ? (~dec_res.has_result | out_load) : out_load);
    dec_step  = s1_step & is_decode;
    s1_retire = s1_step & (is_decode | enc_last);
    out_push  = s1_step & (~is_decode | dec_res.has_result);
    in_ready  = ~s1_valid_r | s1_retire;
    in_fire   = in_valid & in_ready;

    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_retire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_step && !is_decode) begin
      enc_idx_nxt = enc_last ? '0 : enc_idx_r + 4'd1;
    end else begin
      enc_idx_nxt = enc_idx_r;
    end

    if (out_push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      enc_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      enc_idx_r   <= enc_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r  <= in_mode;
      s1_value_r <= in_plain_value;
      s1_byte_r  <= in_byte;
      s1_eod_r   <= in_end_of_data;
    end
  end

  // Encode results carry the coded length on every byte; decode results carry
  // no coded byte.
  always_ff @(posedge clk) begin
    if (out_push) begin
      if (is_decode) begin
        out_byte_r   <= '0;
        out_last_r   <= 1'b0;
        out_value_r  <= dec_res.value;
        out_vvalid_r <= dec_res.value_valid;
        out_len_r    <= dec_res.length;
        out_status_r <= dec_res.status;
      end else begin
        out_byte_r   <= enc_byte;
        out_last_r   <= enc_last;
        out_value_r  <= '0;
        out_vvalid_r <= 1'b0;
        out_len_r    <= enc_n + 4'd1;
        out_status_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_byte_last     = out_last_r;
  assign out_decoded_value = out_value_r;
  assign out_value_valid   = out_vvalid_r;
  assign out_coded_length  = out_len_r;
  assign out_status        = out_status_r;

endmodule

FILE: rtl/v7z_checker.sv
`include "varint_7z_number_codec_macros.svh"

module v7z_checker
  import v7z_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_mode,
  input logic [ValueW-1:0] in_plain_value,
  input logic [ByteW-1:0]  in_byte,
  input logic              in_end_of_data,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ByteW-1:0]  out_byte,
  input logic              out_byte_last,
  input logic [ValueW-1:0] out_decoded_value,
  input logic              out_value_valid,
  input logic [LenW-1:0]   out_coded_length,
  input logic              out_status
);

  // A stalled result stays offered.
  `V7Z_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A finished number never carries encoder fields and has a real length.
  `V7Z_ASSERT_IMPLY(a_value_clean, clk, rst_n, out_valid && out_value_valid,
    out_byte == '0 && !out_byte_last && !out_status && out_coded_length != '0)

  // A truncation report carries nothing else.
  `V7Z_ASSERT_IMPLY(a_trunc_clean, clk, rst_n, out_valid && out_status,
    !out_value_valid && out_coded_length == '0 && out_decoded_value == '0)

  // A one-byte encoding is its own last byte.
  `V7Z_ASSERT_IMPLY(a_single_last, clk, rst_n,
    out_valid && !out_value_valid && !out_status && out_coded_length == 4'd1,
    out_byte_last)

endmodule

bind varint_7z_number_codec v7z_checker u_v7z_checker (.*);
